### rtl/atr_pkg.sv
// Shared types and constants for the address range table.
`default_nettype none

package atr_pkg;

    // Field widths
    localparam int unsigned ADDR_W   = 64;
    localparam int unsigned TGT_W    = 16;
    localparam int unsigned REQ_W    = 2;
    localparam int unsigned STATUS_W = 3;

    // Default table depth
    localparam int unsigned ATR_ENTRIES = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERLAP  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOHIT    = 3'd6;

    // One table entry: range [base, limit) and its target id
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] limit;
        logic [TGT_W-1:0]  target;
    } t_entry;

    // Query broadcast to every cell
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] qend;
        logic              is_remove;
    } t_query;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic live;    // cell index below entry count
        logic eval;    // capture compare result this cycle
        logic wr_new;  // load the new entry
        logic shift;   // take the neighbour's entry (close-up after remove)
    } t_cell_ctl;

endpackage

`default_nettype wire

### rtl/atr_cell.sv
// One table cell: holds an entry, compares it against the query, shifts along the chain.
`default_nettype none

module atr_cell
    import atr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire t_query    i_query,
    input  wire t_entry    i_new,
    input  wire t_entry    i_next,
    output t_entry         o_entry,
    output logic           o_match
);

    t_entry r_entry;
    t_entry n_entry;
    logic   r_match;
    logic   n_match;
    logic   w_overlap;
    logic   w_same;

    // Overlap of [addr, qend) with [base, limit), and exact begin match
    always_comb begin
        w_overlap = (i_query.addr < r_entry.limit) && (i_query.qend > r_entry.base);
        w_same    = (r_entry.base == i_query.addr);
    end

    // Entry update: append or close-up shift
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.wr_new) begin
            n_entry = i_new;
        end else if (i_ctl.shift) begin
            n_entry = i_next;
        end
    end

    // Match flag captured once per transaction
    always_comb begin
        n_match = r_match;
        if (i_ctl.eval) begin
            n_match = i_ctl.live && (i_query.is_remove ? w_same : w_overlap);
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else begin
            r_match <= n_match;
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

`default_nettype wire

### rtl/address_range_table.sv
// Address range table: top level with sequencer, cell chain and output register.
// An ordered table of up to ENTRIES non-overlapping ranges held in a chain of cells,
// one entry per cell; every cell compares its range against a request in parallel,
// and a remove closes the gap by shifting each later cell's entry into its neighbour
// at once. One transaction is worked on at a time. Add, remove and a lookup with no
// hit pass through accept, compare and result states before the next acceptance. A
// lookup with hits passes each hit through a pick stage (first pending cell), a clip
// stage (max/min against the query) and a subtract stage into the output register.
// A result waits in the output register while the block accepts the next transaction;
// a stall on the output holds the sequencer in its result state.
`default_nettype none

module address_range_table
    import atr_pkg::*;
#(
    parameter int unsigned ENTRIES = ATR_ENTRIES
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // request channel
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [REQ_W-1:0]    i_req_type,
    input  wire logic [ADDR_W-1:0]   i_addr,
    input  wire logic [ADDR_W-1:0]   i_size,
    input  wire logic [TGT_W-1:0]    i_target_id,
    // result channel
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [STATUS_W-1:0]      o_status,
    output logic [TGT_W-1:0]         o_hit_target,
    output logic [ADDR_W-1:0]        o_entry_base,
    output logic [ADDR_W-1:0]        o_base_offset,
    output logic [ADDR_W-1:0]        o_hit_length,
    output logic                     o_last
);

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EVAL = 6'b000010,
        S_ACT  = 6'b000100,
        S_SEL  = 6'b001000,
        S_CLIP = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    // Control registers
    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [ENTRIES-1:0]   r_pend, n_pend;
    logic                 r_out_valid, n_out_valid;

    // Payload registers
    logic [REQ_W-1:0]     r_req;
    logic [ADDR_W-1:0]    r_addr;
    logic [ADDR_W-1:0]    r_end;
    logic [TGT_W-1:0]     r_tgt;
    logic                 r_bad;
    t_entry               r_sel;
    logic                 r_sel_last;
    logic [ADDR_W-1:0]    r_hb;
    logic [ADDR_W-1:0]    r_he;
    logic [STATUS_W-1:0]  r_out_status;
    logic [TGT_W-1:0]     r_out_target;
    logic [ADDR_W-1:0]    r_out_begin;
    logic [ADDR_W-1:0]    r_out_offset;
    logic [ADDR_W-1:0]    r_out_length;
    logic                 r_out_last;

    logic [STATUS_W-1:0]  n_out_status;
    logic [TGT_W-1:0]     n_out_target;
    logic [ADDR_W-1:0]    n_out_begin;
    logic [ADDR_W-1:0]    n_out_offset;
    logic [ADDR_W-1:0]    n_out_length;
    logic                 n_out_last;
    logic                 w_emit;

    // Datapath helpers
    logic                 w_accept;
    logic                 w_slot_free;
    logic [ADDR_W-1:0]    w_size_eff;
    logic [ADDR_W:0]      w_sum;
    logic [ENTRIES-1:0]   w_match;
    logic                 w_any;
    logic [IW-1:0]        w_first;
    logic [IW-1:0]        w_pick;
    logic                 w_full;
    logic                 w_add_commit;
    logic                 w_rm_commit;
    t_query               w_query;
    t_entry               w_new;
    t_entry               w_entry [ENTRIES];
    t_cell_ctl            w_ctl   [ENTRIES];

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // End of range: size 0 counts as one byte; carry out flags wrap
    always_comb begin
        w_size_eff = (i_size == '0) ? ADDR_W'(1) : i_size;
        w_sum      = {1'b0, i_addr} + {1'b0, w_size_eff};
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= i_req_type;
            r_addr <= i_addr;
            r_end  <= w_sum[ADDR_W] ? '1 : w_sum[ADDR_W-1:0];
            r_tgt  <= i_target_id;
            r_bad  <= (i_size == '0) || w_sum[ADDR_W];
        end
    end

    // Broadcast query and new entry
    always_comb begin
        w_query.addr      = r_addr;
        w_query.qend      = r_end;
        w_query.is_remove = (r_req == REQ_REMOVE);
        w_new.base        = r_addr;
        w_new.limit       = r_end;
        w_new.target      = r_tgt;
    end

    // Cell chain
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        t_entry w_next;

        if (g < ENTRIES - 1) begin : g_mid
            assign w_next = w_entry[g + 1];
        end else begin : g_tail
            assign w_next = w_entry[g];
        end

        always_comb begin
            w_ctl[g].live   = (r_count > CW'(g));
            w_ctl[g].eval   = (r_state == S_EVAL);
            w_ctl[g].wr_new = w_add_commit && (r_count == CW'(g));
            w_ctl[g].shift  = w_rm_commit && (IW'(g) >= w_first);
        end

        atr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_query (w_query),
            .i_new   (w_new),
            .i_next  (w_next),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    // First matching cell, and first pending hit
    always_comb begin
        w_first = '0;
        w_pick  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_first = IW'(i);
            end
            if (r_pend[i]) begin
                w_pick = IW'(i);
            end
        end
    end

    assign w_any  = |w_match;
    assign w_full = (r_count == CW'(ENTRIES));

    // Table updates commit when the status result goes out
    assign w_add_commit = (r_state == S_ACT) && w_slot_free && (r_req == REQ_ADD) &&
                          !r_bad && !w_any && !w_full;
    assign w_rm_commit  = (r_state == S_ACT) && w_slot_free && (r_req == REQ_REMOVE) &&
                          w_any;

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pend       = r_pend;
        w_emit       = 1'b0;
        n_out_status = ST_OK;
        n_out_target = '0;
        n_out_begin  = '0;
        n_out_offset = '0;
        n_out_length = '0;
        n_out_last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_req_type == REQ_ADD || i_req_type == REQ_REMOVE ||
                                 i_req_type == REQ_LOOKUP)) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_ACT;
            end
            S_ACT: begin
                if (w_slot_free) begin
                    case (r_req)
                        REQ_ADD: begin
                            w_emit  = 1'b1;
                            n_state = S_IDLE;
                            if (r_bad) begin
                                n_out_status = ST_BAD;
                            end else if (w_any) begin
                                n_out_status = ST_OVERLAP;
                            end else if (w_full) begin
                                n_out_status = ST_FULL;
                            end else begin
                                n_out_status = ST_OK;
                                n_count      = r_count + CW'(1);
                            end
                        end
                        REQ_REMOVE: begin
                            w_emit  = 1'b1;
                            n_state = S_IDLE;
                            if (w_any) begin
                                n_out_status = ST_OK;
                                n_count      = r_count - CW'(1);
                            end else begin
                                n_out_status = ST_NOTFOUND;
                            end
                        end
                        default: begin
                            if (w_any) begin
                                n_pend  = w_match;
                                n_state = S_SEL;
                            end else begin
                                w_emit       = 1'b1;
                                n_out_status = ST_NOHIT;
                                n_state      = S_IDLE;
                            end
                        end
                    endcase
                end
            end
            S_SEL: begin
                n_pend[w_pick] = 1'b0;
                n_state        = S_CLIP;
            end
            S_CLIP: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    w_emit       = 1'b1;
                    n_out_status = ST_HIT;
                    n_out_target = r_sel.target;
                    n_out_begin  = r_sel.base;
                    n_out_offset = r_hb - r_sel.base;
                    n_out_length = r_he - r_hb;
                    n_out_last   = r_sel_last;
                    n_state      = r_sel_last ? S_IDLE : S_SEL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = w_emit || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Hit pick and clip stages
    always_ff @(posedge i_clk) begin
        if (r_state == S_SEL) begin
            r_sel      <= w_entry[w_pick];
            r_sel_last <= (n_pend == '0);
        end
        if (r_state == S_CLIP) begin
            r_hb <= (r_addr > r_sel.base) ? r_addr : r_sel.base;
            r_he <= (r_end < r_sel.limit) ? r_end : r_sel.limit;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_status <= n_out_status;
            r_out_target <= n_out_target;
            r_out_begin  <= n_out_begin;
            r_out_offset <= n_out_offset;
            r_out_length <= n_out_length;
            r_out_last   <= n_out_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_hit_target  = r_out_target;
    assign o_entry_base  = r_out_begin;
    assign o_base_offset = r_out_offset;
    assign o_hit_length  = r_out_length;
    assign o_last        = r_out_last;

    // Checks
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("entry count exceeds table depth");

    a_add_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_add_commit |=> r_count == $past(r_count) + CW'(1))
        else $error("successful add did not grow the table");

    a_sel_pending : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEL) |-> (r_pend != '0))
        else $error("hit pick with no pending hit");

    a_hit_length : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_HIT) |-> (o_hit_length != '0))
        else $error("hit transaction with empty overlap");

endmodule

`default_nettype wire
